@@ hw/rtl/oli_pkg.sv @@
// Shared types and constants for the ordered list block.
// Used by oli_ctrl, oli_datapath and ordered_list_insert_remove_top.
`timescale 1ns / 1ps
package oli_pkg;

  localparam int unsigned CAPACITY_DEF    = 16;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  localparam int unsigned CMD_W     = 4;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned VAL_IN_W  = 32;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned ST_W      = 3;
  localparam int unsigned CNT_OUT_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ        = 4'd0,
    CMD_APPEND      = 4'd1,
    CMD_INSERT      = 4'd2,
    CMD_REMOVE_LAST = 4'd3,
    CMD_REMOVE_AT   = 4'd4,
    CMD_REMOVE_RUN  = 4'd5,
    CMD_TRUNCATE    = 4'd6,
    CMD_REPLACE     = 4'd7,
    CMD_COUNT       = 4'd8
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 3'd0,
    ST_INDEX = 3'd1,
    ST_EMPTY = 3'd2,
    ST_RUN   = 3'd3,
    ST_FULL  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_WRITE,
    OP_SHIFT_UP,
    OP_SHIFT_DOWN,
    OP_CLEAR_ABOVE
  } op_e;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [POS_W-1:0]    position;
    logic [VAL_IN_W-1:0] item_value;
    logic [LEN_W-1:0]    run_length;
  } in_t;

  typedef struct packed {
    logic [ST_W-1:0]      status;
    logic [VAL_IN_W-1:0]  read_value;
    logic [CNT_OUT_W-1:0] element_count;
  } out_t;

  typedef struct packed {
    op_e  op;
    logic load_item;
    logic check;
    logic load_result;
  } oli_ctrl_t;

  typedef struct packed {
    cmd_e             cmd;
    status_e          err;
    logic [LEN_W-1:0] run_len;
  } oli_status_t;

endpackage

@@ hw/rtl/ordered_list_insert_remove_top.sv @@
// Top level of the ordered list block: fixed-capacity list with read, append,
// insert, remove, truncate, replace and count commands. Depends on oli_pkg,
// oli_ctrl, oli_datapath.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------
//   in      | input     | in_valid_i / in_stall_o  | in_beat_i
//   out     | output    | out_valid_o / out_stall_i| out_beat_o
//
// Each command passes the check and finish steps between accepts; remove
// run of N elements adds run steps, one shift of all cells per cycle.
// The result register loads in the finish step, after the last update.
// Reset clears the count and all slots at once; no clearing pass.
// A result held by out_stall_i does not block the next input beat; only
// the finish step waits for the result register to free up.
`timescale 1ns / 1ps
module ordered_list_insert_remove_top import oli_pkg::*; #(
  parameter int unsigned Capacity   = CAPACITY_DEF,
  parameter int unsigned ValueWidth = VALUE_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_beat_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_beat_o
);

  oli_ctrl_t   ctrl;
  oli_status_t status;

  oli_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .ctrl_o      (ctrl)
  );

  oli_datapath #(
    .Capacity   (Capacity),
    .ValueWidth (ValueWidth)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_beat_i  (in_beat_i),
    .ctrl_i     (ctrl),
    .status_o   (status),
    .out_beat_o (out_beat_o)
  );

endmodule

@@ hw/rtl/oli_datapath.sv @@
// Datapath of the ordered list: slot cells, element count, index checks
// and the result register. Depends on oli_pkg; driven by oli_ctrl.
`timescale 1ns / 1ps
module oli_datapath import oli_pkg::*; #(
  parameter int unsigned Capacity   = CAPACITY_DEF,
  parameter int unsigned ValueWidth = VALUE_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  in_t         in_beat_i,
  input  oli_ctrl_t   ctrl_i,
  output oli_status_t status_o,
  output out_t        out_beat_o
);

  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam int unsigned IdxW = $clog2(Capacity);
  localparam int unsigned CmpW = ((CntW > POS_W) ? CntW : POS_W) + 1;

  in_t                  item_q;
  logic [CntW-1:0]      count_q, count_d;
  status_e              err_q;
  out_t                 res_q;
  logic [ValueWidth-1:0] slots_q [Capacity];
  logic [ValueWidth-1:0] slots_d [Capacity];

  cmd_e                  cmd;
  status_e               err;
  logic [CmpW-1:0]       pos_c, cnt_c, len_c, at;
  logic                  empty, full, idx_bad, run_bad;
  logic [ValueWidth+VAL_IN_W-1:0] val_wide;
  logic [ValueWidth-1:0] val;
  logic [ValueWidth-1:0] rd_slot;
  logic [ValueWidth+VAL_IN_W-1:0] rd_wide;
  logic [CntW+CNT_OUT_W-1:0] cnt_wide;

  assign cmd     = cmd_e'(item_q.command);
  assign pos_c   = CmpW'(item_q.position);
  assign cnt_c   = CmpW'(count_q);
  assign len_c   = CmpW'(item_q.run_length);
  assign empty   = (count_q == '0);
  assign full    = (count_q == CntW'(Capacity));
  assign idx_bad = (pos_c >= cnt_c);
  assign run_bad = ((pos_c + len_c) > cnt_c);

  assign val_wide = {{ValueWidth{1'b0}}, item_q.item_value};
  assign val      = val_wide[ValueWidth-1:0];

  always_comb begin
    case (cmd)
      CMD_READ, CMD_REMOVE_AT, CMD_TRUNCATE, CMD_REPLACE: begin
        err = empty ? ST_EMPTY : (idx_bad ? ST_INDEX : ST_OK);
      end
      CMD_REMOVE_RUN: begin
        if (empty) begin
          err = ST_EMPTY;
        end else if (idx_bad) begin
          err = ST_INDEX;
        end else if (item_q.run_length != '0 && run_bad) begin
          err = ST_RUN;
        end else begin
          err = ST_OK;
        end
      end
      CMD_APPEND: begin
        err = full ? ST_FULL : ST_OK;
      end
      CMD_INSERT: begin
        err = (pos_c > cnt_c) ? ST_INDEX : (full ? ST_FULL : ST_OK);
      end
      CMD_REMOVE_LAST: begin
        err = empty ? ST_EMPTY : ST_OK;
      end
      default: begin
        err = ST_OK;
      end
    endcase
  end

  always_comb begin
    case (cmd)
      CMD_APPEND:      at = cnt_c;
      CMD_REMOVE_LAST: at = cnt_c - CmpW'(1);
      default:         at = pos_c;
    endcase
  end

  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    localparam logic [CmpW-1:0] Idx = CmpW'(g);
    logic [ValueWidth-1:0] below;
    logic [ValueWidth-1:0] above;

    if (g == 0) begin : g_first
      assign below = '0;
    end else begin : g_below
      assign below = slots_q[g-1];
    end
    if (g == Capacity - 1) begin : g_last
      assign above = '0;
    end else begin : g_above
      assign above = slots_q[g+1];
    end

    always_comb begin
      slots_d[g] = slots_q[g];
      case (ctrl_i.op)
        OP_WRITE: begin
          if (Idx == at) slots_d[g] = val;
        end
        OP_SHIFT_UP: begin
          if (Idx == at) begin
            slots_d[g] = val;
          end else if (Idx > at && Idx <= cnt_c) begin
            slots_d[g] = below;
          end
        end
        OP_SHIFT_DOWN: begin
          if (Idx >= at && (Idx + CmpW'(1)) < cnt_c) begin
            slots_d[g] = above;
          end else if ((Idx + CmpW'(1)) == cnt_c) begin
            slots_d[g] = '0;
          end
        end
        OP_CLEAR_ABOVE: begin
          if (Idx > at) slots_d[g] = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (ctrl_i.op)
      OP_SHIFT_UP:    count_d = count_q + CntW'(1);
      OP_SHIFT_DOWN:  count_d = count_q - CntW'(1);
      OP_CLEAR_ABOVE: count_d = CntW'(pos_c + CmpW'(1));
      default:        count_d = count_q;
    endcase
  end

  assign rd_slot  = slots_q[IdxW'(item_q.position)];
  assign rd_wide  = {{VAL_IN_W{1'b0}}, rd_slot};
  assign cnt_wide = {{CNT_OUT_W{1'b0}}, count_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int i = 0; i < Capacity; i++) slots_q[i] <= '0;
    end else begin
      count_q <= count_d;
      slots_q <= slots_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_item) item_q <= in_beat_i;
    if (ctrl_i.check) err_q <= err;
    if (ctrl_i.load_result) begin
      res_q.status        <= err_q;
      res_q.read_value    <= (cmd == CMD_READ && err_q == ST_OK) ?
                             rd_wide[VAL_IN_W-1:0] : '0;
      res_q.element_count <= cnt_wide[CNT_OUT_W-1:0];
    end
  end

  assign status_o.cmd     = cmd;
  assign status_o.err     = err;
  assign status_o.run_len = item_q.run_length;
  assign out_beat_o       = res_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity))
    else $error("element count above capacity");
  a_no_grow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.op == OP_SHIFT_UP |-> !full)
    else $error("shift up on a full list");
  a_no_shrink_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.op == OP_SHIFT_DOWN |-> !empty)
    else $error("shift down on an empty list");
`endif

endmodule

@@ hw/rtl/oli_ctrl.sv @@
// Controller of the ordered list: command sequencing, run removal loop
// and output handshake. Depends on oli_pkg; drives oli_datapath.
`timescale 1ns / 1ps
module oli_ctrl import oli_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  input  oli_status_t status_i,
  output oli_ctrl_t   ctrl_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_RUN,
    S_FINISH
  } state_e;

  state_e           state_q;
  logic [LEN_W-1:0] run_cnt_q;
  logic             out_valid_q;
  logic             res_free;

  assign res_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    ctrl_o             = '0;
    ctrl_o.op          = OP_NONE;
    ctrl_o.load_item   = (state_q == S_IDLE) && in_valid_i;
    ctrl_o.check       = (state_q == S_CHECK);
    ctrl_o.load_result = (state_q == S_FINISH) && res_free;
    case (state_q)
      S_CHECK: begin
        if (status_i.err == ST_OK) begin
          case (status_i.cmd)
            CMD_APPEND, CMD_INSERT:        ctrl_o.op = OP_SHIFT_UP;
            CMD_REMOVE_LAST, CMD_REMOVE_AT: ctrl_o.op = OP_SHIFT_DOWN;
            CMD_REMOVE_RUN: begin
              if (status_i.run_len != '0) ctrl_o.op = OP_SHIFT_DOWN;
            end
            CMD_TRUNCATE: ctrl_o.op = OP_CLEAR_ABOVE;
            CMD_REPLACE:  ctrl_o.op = OP_WRITE;
            default:      ctrl_o.op = OP_NONE;
          endcase
        end
      end
      S_RUN: begin
        ctrl_o.op = OP_SHIFT_DOWN;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      run_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_FINISH && res_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_CHECK;
        end
        S_CHECK: begin
          if (status_i.err == ST_OK && status_i.cmd == CMD_REMOVE_RUN &&
              status_i.run_len > LEN_W'(1)) begin
            run_cnt_q <= status_i.run_len - LEN_W'(1);
            state_q   <= S_RUN;
          end else begin
            state_q <= S_FINISH;
          end
        end
        S_RUN: begin
          run_cnt_q <= run_cnt_q - LEN_W'(1);
          if (run_cnt_q == LEN_W'(1)) state_q <= S_FINISH;
        end
        S_FINISH: begin
          if (res_free) state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_run_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RUN |-> run_cnt_q != '0)
    else $error("run loop with zero count");
  a_result_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.load_result |-> !(out_valid_q && out_stall_i))
    else $error("result overwritten while stalled");
  a_accept_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.load_item |=> state_q == S_CHECK)
    else $error("accepted beat not checked");
`endif

endmodule
